// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the MIDI framer blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MBSF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define MBSF_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- design/mbsf_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI framer package
// Constants, result record types and helpers shared by the framer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbsf_pkg;

   localparam int unsigned SYSEX_BUFFER_BYTES = 1024;
   localparam int unsigned LIMIT_W            = 10;
   localparam int unsigned LIMIT_CEIL_INT     =
      (SYSEX_BUFFER_BYTES - 1 < (1 << LIMIT_W) - 1) ? SYSEX_BUFFER_BYTES - 1
                                                    : (1 << LIMIT_W) - 1;
   localparam logic [LIMIT_W-1:0] LIMIT_CEIL  = LIMIT_W'(LIMIT_CEIL_INT);
   localparam logic [LIMIT_W-1:0] LIMIT_FLOOR = LIMIT_W'(3);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1023);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Result kinds
   localparam logic [2:0] KIND_CHANNEL  = 3'd0;
   localparam logic [2:0] KIND_COMMON   = 3'd1;
   localparam logic [2:0] KIND_REALTIME = 3'd2;
   localparam logic [2:0] KIND_SX_BYTE  = 3'd3;
   localparam logic [2:0] KIND_SX_CLOSE = 3'd4;

   // Sysex close reasons
   localparam logic [1:0] SX_ERR_NONE      = 2'd0;
   localparam logic [1:0] SX_ERR_TRUNCATED = 2'd1;
   localparam logic [1:0] SX_ERR_ABORTED   = 2'd2;

   // Status bytes and status nibbles
   localparam logic [7:0] ST_SYSEX_START = 8'hF0;
   localparam logic [7:0] ST_MTC_QUARTER = 8'hF1;
   localparam logic [7:0] ST_SONG_SELECT = 8'hF3;
   localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
   localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
   localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
   localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
   localparam logic [7:0] ST_REALTIME_LO = 8'hF8;
   localparam logic [3:0] HI_PROGRAM     = 4'hC;
   localparam logic [3:0] HI_PRESSURE    = 4'hD;
   localparam logic [3:0] HI_SYSTEM      = 4'hF;

   localparam logic [13:0] BEND_OFFSET = 14'd8192;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] status;
      logic [6:0] first;
      logic [6:0] second;
      logic [7:0] sx_byte;
      logic       sx_end;
      logic [1:0] sx_err;
      logic       last;
   } rec_type;

   // One queue entry holds every result of one input item.
   typedef struct packed {
      rec_type lead;
      rec_type trail;
      logic    has_trail;
   } entry_type;

   function automatic rec_type make_rec(input logic [2:0] kind,
                                        input logic [7:0] status,
                                        input logic [6:0] first,
                                        input logic [6:0] second,
                                        input logic [7:0] sx_byte,
                                        input logic       sx_end,
                                        input logic [1:0] sx_err);
      rec_type r;
      r.kind    = kind;
      r.status  = status;
      r.first   = first;
      r.second  = second;
      r.sx_byte = sx_byte;
      r.sx_end  = sx_end;
      r.sx_err  = sx_err;
      r.last    = 1'b0;
      return r;
   endfunction

endpackage

// ----- design/mbsf_front.sv -----
// ----------------------------------------------------------------------------
// MIDI framer front end
// Accepts bytes, tracks running status and sysex state, builds result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbsf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic [mbsf_pkg::LIMIT_W-1:0] limit,
   input  logic                      queue_full,
   output logic                      push,
   output mbsf_pkg::entry_type       push_entry
);
   import mbsf_pkg::*;

   logic [7:0]         rs_ff, rs_in;
   logic               seen_ff, seen_in;
   logic [6:0]         held_ff, held_in;
   logic               insx_ff, insx_in;
   logic               drop_ff, drop_in;
   logic [LIMIT_W-1:0] cnt_ff, cnt_in;

   logic [LIMIT_W-1:0] lim_eff;
   logic               accept;
   logic               abort_valid, main_valid;
   rec_type            abort_rec, main_rec;
   logic               one_data;
   logic [2:0]         msg_kind;
   logic [7:0]         b;

   assign b         = req_rx_byte;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      lim_eff = limit;
      if (lim_eff < LIMIT_FLOOR) begin
         lim_eff = LIMIT_FLOOR;
      end
      if (lim_eff > LIMIT_CEIL) begin
         lim_eff = LIMIT_CEIL;
      end
   end

   assign one_data = (rs_ff[7:4] == HI_PROGRAM) || (rs_ff[7:4] == HI_PRESSURE) ||
                     (rs_ff == ST_MTC_QUARTER) || (rs_ff == ST_SONG_SELECT) ||
                     (rs_ff == ST_UNDEF_F5);
   assign msg_kind = (rs_ff[7:4] == HI_SYSTEM) ? KIND_COMMON : KIND_CHANNEL;

   always_comb begin
      rs_in       = rs_ff;
      seen_in     = seen_ff;
      held_in     = held_ff;
      insx_in     = insx_ff;
      drop_in     = drop_ff;
      cnt_in      = cnt_ff;
      abort_valid = 1'b0;
      main_valid  = 1'b0;
      abort_rec   = make_rec(KIND_SX_CLOSE, ST_SYSEX_START, 7'd0, 7'd0, 8'd0, 1'b1,
                             SX_ERR_ABORTED);
      main_rec    = '0;

      if (b >= ST_REALTIME_LO) begin
         main_valid = 1'b1;
         main_rec   = make_rec(KIND_REALTIME, b, 7'd0, 7'd0, 8'd0, 1'b0, SX_ERR_NONE);
      end else if (b[7]) begin
         if (insx_ff && (b == ST_SYSEX_END)) begin
            main_valid = 1'b1;
            main_rec   = make_rec(KIND_SX_BYTE, ST_SYSEX_START, 7'd0, 7'd0, b, 1'b1,
                                  SX_ERR_NONE);
            insx_in    = 1'b0;
            cnt_in     = '0;
            rs_in      = '0;
         end else begin
            if (insx_ff) begin
               // Any other status cuts the open sysex short.
               abort_valid = 1'b1;
               insx_in     = 1'b0;
               cnt_in      = '0;
            end
            drop_in = 1'b0;
            seen_in = 1'b0;
            held_in = '0;
            if (b < ST_SYSEX_START) begin
               rs_in = b;
            end else if (b == ST_SYSEX_START) begin
               rs_in      = '0;
               insx_in    = 1'b1;
               cnt_in     = LIMIT_W'(1);
               main_valid = 1'b1;
               main_rec   = make_rec(KIND_SX_BYTE, ST_SYSEX_START, 7'd0, 7'd0, b, 1'b0,
                                     SX_ERR_NONE);
            end else if ((b == ST_UNDEF_F4) || (b == ST_TUNE_REQ)) begin
               rs_in      = '0;
               main_valid = 1'b1;
               main_rec   = make_rec(KIND_COMMON, b, 7'd0, 7'd0, 8'd0, 1'b0, SX_ERR_NONE);
            end else if (b == ST_SYSEX_END) begin
               rs_in = '0;
            end else begin
               rs_in = b;
            end
         end
      end else if (insx_ff) begin
         if (cnt_ff < (lim_eff - LIMIT_W'(1))) begin
            main_valid = 1'b1;
            main_rec   = make_rec(KIND_SX_BYTE, ST_SYSEX_START, 7'd0, 7'd0, b, 1'b0,
                                  SX_ERR_NONE);
            cnt_in     = cnt_ff + LIMIT_W'(1);
         end else begin
            main_valid = 1'b1;
            main_rec   = make_rec(KIND_SX_CLOSE, ST_SYSEX_START, 7'd0, 7'd0, 8'd0, 1'b1,
                                  SX_ERR_TRUNCATED);
            insx_in    = 1'b0;
            cnt_in     = '0;
            drop_in    = 1'b1;
         end
      end else if (!drop_ff && (rs_ff != 8'd0)) begin
         if (one_data) begin
            main_valid = 1'b1;
            main_rec   = make_rec(msg_kind, rs_ff, b[6:0], 7'd0, 8'd0, 1'b0, SX_ERR_NONE);
            seen_in    = 1'b0;
            if (msg_kind == KIND_COMMON) begin
               rs_in = '0;
            end
         end else if (!seen_ff) begin
            held_in = b[6:0];
            seen_in = 1'b1;
         end else begin
            main_valid = 1'b1;
            main_rec   = make_rec(msg_kind, rs_ff, held_ff, b[6:0], 8'd0, 1'b0,
                                  SX_ERR_NONE);
            seen_in    = 1'b0;
            held_in    = '0;
            if (msg_kind == KIND_COMMON) begin
               rs_in = '0;
            end
         end
      end
   end

   always_comb begin
      push_entry = '0;
      if (abort_valid) begin
         push_entry.lead      = abort_rec;
         push_entry.trail     = main_rec;
         push_entry.has_trail = main_valid;
         if (main_valid) begin
            push_entry.trail.last = 1'b1;
         end else begin
            push_entry.lead.last = 1'b1;
         end
      end else begin
         push_entry.lead      = main_rec;
         push_entry.lead.last = 1'b1;
      end
   end

   assign push = accept && (abort_valid || main_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff   <= '0;
         seen_ff <= 1'b0;
         held_ff <= '0;
         insx_ff <= 1'b0;
         drop_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         rs_ff   <= rs_in;
         seen_ff <= seen_in;
         held_ff <= held_in;
         insx_ff <= insx_in;
         drop_ff <= drop_in;
         cnt_ff  <= cnt_in;
      end
   end

   `MBSF_NEVER(a_sx_open_and_dropping, clock, reset, insx_ff && drop_ff,
               "sysex open while dropping")
   `MBSF_ASSERT(a_held_needs_status, clock, reset, !seen_ff || (rs_ff != 8'd0),
                "held data byte without running status")

endmodule

// ----- design/mbsf_queue.sv -----
// ----------------------------------------------------------------------------
// MIDI framer queue
// Short first-in first-out store of result entries between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbsf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mbsf_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output mbsf_pkg::entry_type head
);
   import mbsf_pkg::*;

   entry_type              store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MBSF_NEVER(a_push_when_full, clock, reset, push && full, "push into a full queue")
   `MBSF_NEVER(a_pop_when_empty, clock, reset, pop && empty, "pop from an empty queue")

endmodule

// ----- design/mbsf_back.sv -----
// ----------------------------------------------------------------------------
// MIDI framer back end
// Unpacks queue entries into single results and holds them in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbsf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  mbsf_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_status_byte,
   output logic [3:0]          rsp_channel,
   output logic [6:0]          rsp_first_data,
   output logic [6:0]          rsp_second_data,
   output logic [13:0]         rsp_combined_value,
   output logic signed [13:0]  rsp_bend_signed,
   output logic [7:0]          rsp_sysex_byte,
   output logic                rsp_sysex_end,
   output logic [1:0]          rsp_sysex_error,
   output logic                rsp_last_of_input
);
   import mbsf_pkg::*;

   logic        rsp_valid_ff;
   rec_type     out_ff;
   logic [3:0]  chan_ff;
   logic [13:0] comb_ff;
   logic [13:0] bend_ff;
   rec_type     pend_ff;
   logic        pend_valid_ff;

   logic        load;
   rec_type     load_rec;
   logic [13:0] load_comb;
   logic        is_msg;

   assign load     = !rsp_valid_ff || !rsp_stall;
   assign pop      = load && !pend_valid_ff && !empty;
   assign load_rec = pend_valid_ff ? pend_ff : head.lead;

   assign is_msg    = (load_rec.kind == KIND_CHANNEL) || (load_rec.kind == KIND_COMMON);
   assign load_comb = is_msg ? {load_rec.second, load_rec.first} : 14'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (load) begin
         if (pend_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= !empty;
            pend_valid_ff <= !empty && head.has_trail;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= load_rec;
         chan_ff <= (load_rec.kind == KIND_CHANNEL) ? load_rec.status[3:0] : 4'd0;
         comb_ff <= load_comb;
         bend_ff <= is_msg ? (load_comb - BEND_OFFSET) : 14'd0;
         if (!pend_valid_ff) begin
            pend_ff <= head.trail;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_status_byte    = out_ff.status;
   assign rsp_channel        = chan_ff;
   assign rsp_first_data     = out_ff.first;
   assign rsp_second_data    = out_ff.second;
   assign rsp_combined_value = comb_ff;
   assign rsp_bend_signed    = $signed(bend_ff);
   assign rsp_sysex_byte     = out_ff.sx_byte;
   assign rsp_sysex_end      = out_ff.sx_end;
   assign rsp_sysex_error    = out_ff.sx_err;
   assign rsp_last_of_input  = out_ff.last;

   `MBSF_ASSERT(a_pend_behind_output, clock, reset, !pend_valid_ff || rsp_valid_ff,
                "second result pending without a first one shown")
   `MBSF_ASSERT(a_pend_follows, clock, reset,
                (pend_valid_ff && !rsp_stall) |=> (rsp_valid_ff && !pend_valid_ff),
                "pending second result not shown next")

endmodule

// ----- design/midi_byte_stream_framer_core.sv -----
// Path: a byte's results pass through the queue and then the output register.
// Throughput: one byte per cycle while the queue has room and one result per
// cycle while rsp_stall is low; the four-entry queue absorbs two-result bytes.
// Reset: synchronous, active high; clears running status and sysex tracking,
// empties the queue and output register, and sets the sysex length limit to 1023.
// ----------------------------------------------------------------------------
// MIDI byte stream framer
// Frames received serial MIDI bytes into channel, system common, realtime and
// system exclusive results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midi_byte_stream_framer_core (
   input  logic               clock,
   input  logic               reset,
   // Byte input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_status_byte,
   output logic [3:0]         rsp_channel,
   output logic [6:0]         rsp_first_data,
   output logic [6:0]         rsp_second_data,
   output logic [13:0]        rsp_combined_value,
   output logic signed [13:0] rsp_bend_signed,
   output logic [7:0]         rsp_sysex_byte,
   output logic               rsp_sysex_end,
   output logic [1:0]         rsp_sysex_error,
   output logic               rsp_last_of_input,
   // Control register port: the sysex length limit
   input  logic               csr_wr_en,
   input  logic [9:0]         csr_wr_data
);
   import mbsf_pkg::*;

   // The sysex length limit counts every byte of one message, F0 and F7
   // included. Values outside the legal range are clamped by the front end.
   logic [LIMIT_W-1:0] limit_ff;

   // The front end classifies each byte and updates the framing state in the
   // cycle it is accepted. Every result that byte causes (at most two: a sysex
   // abort marker followed by the new message) travels as one queue entry.
   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   mbsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .limit       (limit_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // The queue decouples byte intake from result delivery, so the front end
   // keeps taking bytes while the consumer stalls, until the queue fills.
   mbsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head       (head)
   );

   // The back end splits each entry into single results, works out the
   // channel, the 14-bit combined value and the signed bend value, and holds
   // each result in the output register until the consumer takes it.
   mbsf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (queue_empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_channel        (rsp_channel),
      .rsp_first_data     (rsp_first_data),
      .rsp_second_data    (rsp_second_data),
      .rsp_combined_value (rsp_combined_value),
      .rsp_bend_signed    (rsp_bend_signed),
      .rsp_sysex_byte     (rsp_sysex_byte),
      .rsp_sysex_end      (rsp_sysex_end),
      .rsp_sysex_error    (rsp_sysex_error),
      .rsp_last_of_input  (rsp_last_of_input)
   );

endmodule
